[rtl/core/dmfp_pkg.sv]
package dmfp_pkg;

    // queue between the parser and the output stage
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int NUM_SECTIONS = 4;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_HEADER  = 4'd1,
        PH_QNAME   = 4'd2,
        PH_QTYPE   = 4'd3,
        PH_QCLASS  = 4'd4,
        PH_RRNAME  = 4'd5,
        PH_RRTYPE  = 4'd6,
        PH_RRCLASS = 4'd7,
        PH_TTL     = 4'd8,
        PH_RDLEN   = 4'd9,
        PH_RDATA   = 4'd10
    } t_phase;

    typedef enum logic [3:0] {
        K_ID       = 4'd0,
        K_FLAGS    = 4'd1,
        K_QDCOUNT  = 4'd2,
        K_ANCOUNT  = 4'd3,
        K_NSCOUNT  = 4'd4,
        K_ARCOUNT  = 4'd5,
        K_QNAME    = 4'd6,
        K_QTYPE    = 4'd7,
        K_QCLASS   = 4'd8,
        K_RRNAME   = 4'd9,
        K_RRTYPE   = 4'd10,
        K_RRCLASS  = 4'd11,
        K_TTL      = 4'd12,
        K_RDLENGTH = 4'd13,
        K_RDATA    = 4'd14
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } t_in;

    typedef struct packed {
        t_kind       field_kind;
        logic [1:0]  section;
        logic [15:0] record_index;
        logic [31:0] field_value;
        logic        message_done;
    } t_out;

    typedef struct packed {
        logic        found;
        logic [1:0]  sec;
        logic [15:0] rec;
    } t_seek;

    typedef struct packed {
        logic full;
        logic avail;
    } t_q_stat;

endpackage

[rtl/core/dns_message_field_parser.sv]
// DNS message field parser.
// Input channel: one message byte per word (i_in_valid / o_in_ready, payload
// i_in_word). Set start_req on the first byte of a message; it restarts the
// parse at any point. Bytes before a start or after the final field are
// consumed and give no result.
// Output channel: one parsed field per word (o_out_valid / i_out_ready,
// payload o_out_word): kind, section, record index, big-endian value, and
// message_done on the last field of the message.
// Throughput: one byte per cycle while the queue is not full, set by the parser
// state register, which advances once per accepted byte. A field is written into
// the queue as its last byte is accepted, then moves on to the output register.
// A four-word queue sits between the parser and the output register, so input
// keeps flowing while the receiver stalls; o_in_ready falls only when the
// queue is full, and rises again as soon as the receiver takes a word.
// Reset (synchronous, active low) returns the parser to idle, waiting for a
// start, and empties the queue and output register.
module dns_message_field_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dmfp_pkg::t_in  i_in_word,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dmfp_pkg::t_out o_out_word
);

    dmfp_pkg::t_q_stat q_stat;
    dmfp_pkg::t_out    push_word;
    dmfp_pkg::t_out    head;
    logic              push;
    logic              pop;

    dmfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_q_stat    (q_stat),
        .o_in_ready  (o_in_ready),
        .o_push      (push),
        .o_push_word (push_word)
    );

    dmfp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_word (push_word),
        .i_pop       (pop),
        .o_stat      (q_stat),
        .o_head      (head)
    );

    dmfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

[rtl/core/dmfp_front.sv]
module dmfp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dmfp_pkg::t_in     i_in_word,
    input  dmfp_pkg::t_q_stat i_q_stat,
    output logic              o_in_ready,
    output logic              o_push,
    output dmfp_pkg::t_out    o_push_word
);

    // first record at or after (sec, rec) that the counts say exists
    function automatic dmfp_pkg::t_seek seek_next(
        input logic [dmfp_pkg::NUM_SECTIONS-1:0][15:0] counts,
        input logic [1:0]  sec,
        input logic [16:0] rec
    );
        dmfp_pkg::t_seek r;
        logic [16:0]     cand;
        r    = '0;
        cand = '0;
        for (int s = 0; s < dmfp_pkg::NUM_SECTIONS; s++) begin
            cand = (2'(s) == sec) ? rec : 17'd0;
            if (!r.found && (2'(s) >= sec) && (cand < {1'b0, counts[s]})) begin
                r.found = 1'b1;
                r.sec   = 2'(s);
                r.rec   = cand[15:0];
            end
        end
        return r;
    endfunction

    dmfp_pkg::t_phase r_phase, n_phase, e_phase;
    logic [1:0]  r_idx, n_idx, e_idx;
    logic [31:0] r_acc, n_acc, e_acc;
    logic [dmfp_pkg::NUM_SECTIONS-1:0][15:0] r_counts, n_counts, e_counts;
    logic [1:0]  r_sec, n_sec, e_sec;
    logic [15:0] r_rec, n_rec, e_rec;
    logic [15:0] r_rem, n_rem, e_rem;

    logic            take;
    logic [7:0]      b;
    logic [31:0]     acc_new;
    logic [2:0]      idx_p1;
    logic [2:0]      len;
    logic [15:0]     rem_dec;
    logic            do_seek;
    logic [1:0]      seek_sec;
    logic [16:0]     seek_rec;
    dmfp_pkg::t_seek sk;
    dmfp_pkg::t_out  res;
    logic            emit;

    assign o_in_ready = !i_q_stat.full;
    assign take       = i_in_valid && o_in_ready;
    assign b          = i_in_word.data_byte;

    always_comb begin
        // a start byte drops all parse state and opens a new header
        if (i_in_word.start_req) begin
            e_phase  = dmfp_pkg::PH_HEADER;
            e_idx    = '0;
            e_acc    = '0;
            e_counts = '0;
            e_sec    = '0;
            e_rec    = '0;
            e_rem    = '0;
        end else begin
            e_phase  = r_phase;
            e_idx    = r_idx;
            e_acc    = r_acc;
            e_counts = r_counts;
            e_sec    = r_sec;
            e_rec    = r_rec;
            e_rem    = r_rem;
        end

        n_phase  = e_phase;
        n_idx    = e_idx;
        n_acc    = e_acc;
        n_counts = e_counts;
        n_sec    = e_sec;
        n_rec    = e_rec;
        n_rem    = e_rem;

        acc_new  = {e_acc[23:0], b};
        idx_p1   = {1'b0, e_idx} + 3'd1;
        len      = (e_phase == dmfp_pkg::PH_TTL) ? 3'd4 : 3'd2;
        rem_dec  = e_rem - 16'd1;
        do_seek  = 1'b0;
        seek_sec = e_sec;
        seek_rec = {1'b0, e_rec} + 17'd1;
        emit     = 1'b0;

        res              = '0;
        res.section      = e_sec;
        res.record_index = e_rec;
        res.field_value  = {24'd0, b};

        case (e_phase)
            dmfp_pkg::PH_IDLE: begin
                emit = 1'b0;
            end
            dmfp_pkg::PH_QNAME: begin
                emit           = 1'b1;
                res.field_kind = dmfp_pkg::K_QNAME;
                if (b == 8'd0) begin
                    n_phase = dmfp_pkg::PH_QTYPE;
                    n_idx   = '0;
                    n_acc   = '0;
                end
            end
            dmfp_pkg::PH_RDATA: begin
                emit           = 1'b1;
                res.field_kind = dmfp_pkg::K_RDATA;
                n_rem          = rem_dec;
                do_seek        = (rem_dec == 16'd0);
            end
            default: begin
                n_acc = acc_new;
                if (idx_p1 < len) begin
                    n_idx = idx_p1[1:0];
                end else begin
                    emit            = 1'b1;
                    n_idx           = '0;
                    n_acc           = '0;
                    res.field_value = (len == 3'd4) ? acc_new : {16'd0, acc_new[15:0]};
                    case (e_phase)
                        dmfp_pkg::PH_HEADER: begin
                            res.field_kind   = dmfp_pkg::t_kind'(e_rec[3:0]);
                            res.section      = '0;
                            res.record_index = '0;
                            if (e_rec[3:0] inside {[4'd2:4'd5]}) begin
                                n_counts[e_rec[1:0] - 2'd2] = acc_new[15:0];
                            end
                            if (e_rec < 16'd5) begin
                                n_rec = e_rec + 16'd1;
                            end else begin
                                do_seek  = 1'b1;
                                seek_sec = '0;
                                seek_rec = '0;
                            end
                        end
                        dmfp_pkg::PH_QTYPE: begin
                            res.field_kind = dmfp_pkg::K_QTYPE;
                            n_phase        = dmfp_pkg::PH_QCLASS;
                        end
                        dmfp_pkg::PH_QCLASS: begin
                            res.field_kind = dmfp_pkg::K_QCLASS;
                            do_seek        = 1'b1;
                            seek_sec       = '0;
                        end
                        dmfp_pkg::PH_RRNAME: begin
                            res.field_kind = dmfp_pkg::K_RRNAME;
                            n_phase        = dmfp_pkg::PH_RRTYPE;
                        end
                        dmfp_pkg::PH_RRTYPE: begin
                            res.field_kind = dmfp_pkg::K_RRTYPE;
                            n_phase        = dmfp_pkg::PH_RRCLASS;
                        end
                        dmfp_pkg::PH_RRCLASS: begin
                            res.field_kind = dmfp_pkg::K_RRCLASS;
                            n_phase        = dmfp_pkg::PH_TTL;
                        end
                        dmfp_pkg::PH_TTL: begin
                            res.field_kind = dmfp_pkg::K_TTL;
                            n_phase        = dmfp_pkg::PH_RDLEN;
                        end
                        default: begin
                            res.field_kind = dmfp_pkg::K_RDLENGTH;
                            n_rem          = acc_new[15:0];
                            if (acc_new[15:0] == 16'd0) begin
                                do_seek = 1'b1;
                            end else begin
                                n_phase = dmfp_pkg::PH_RDATA;
                            end
                        end
                    endcase
                end
            end
        endcase

        // seek uses the counts as updated by this byte
        sk = seek_next(n_counts, seek_sec, seek_rec);
        if (do_seek) begin
            n_idx = '0;
            n_acc = '0;
            res.message_done = !sk.found;
            if (sk.found) begin
                n_sec   = sk.sec;
                n_rec   = sk.rec;
                n_phase = (sk.sec == 2'd0) ? dmfp_pkg::PH_QNAME : dmfp_pkg::PH_RRNAME;
            end else begin
                n_phase = dmfp_pkg::PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= dmfp_pkg::PH_IDLE;
            r_idx    <= '0;
            r_acc    <= '0;
            r_counts <= '0;
            r_sec    <= '0;
            r_rec    <= '0;
            r_rem    <= '0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_acc    <= n_acc;
            r_counts <= n_counts;
            r_sec    <= n_sec;
            r_rec    <= n_rec;
            r_rem    <= n_rem;
        end
    end

    assign o_push      = take && emit;
    assign o_push_word = res;

    a_rdata_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == dmfp_pkg::PH_RDATA |-> r_rem != 16'd0)
        else $error("rdata phase with no bytes left");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != dmfp_pkg::PH_TTL |-> r_idx <= 2'd1)
        else $error("byte index beyond two-byte field");

    a_header_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == dmfp_pkg::PH_HEADER |-> r_rec <= 16'd5)
        else $error("header field counter out of range");

endmodule

[rtl/core/dmfp_queue.sv]
module dmfp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dmfp_pkg::t_out    i_push_word,
    input  logic              i_pop,
    output dmfp_pkg::t_q_stat o_stat,
    output dmfp_pkg::t_out    o_head
);

    dmfp_pkg::t_out r_mem [dmfp_pkg::Q_DEPTH];
    logic [dmfp_pkg::Q_AW-1:0] r_wr, r_rd;
    logic [dmfp_pkg::Q_CW-1:0] r_count, n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_word;
        end
    end

    assign o_stat = '{full:  (r_count == dmfp_pkg::Q_CW'(dmfp_pkg::Q_DEPTH)),
                      avail: (r_count != '0)};
    assign o_head = r_mem[r_rd];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.full |-> !i_push)
        else $error("word pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_stat.avail)
        else $error("word popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dmfp_pkg::Q_CW'(dmfp_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

endmodule

[rtl/core/dmfp_back.sv]
module dmfp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dmfp_pkg::t_q_stat i_q_stat,
    input  dmfp_pkg::t_out    i_head,
    output logic              o_pop,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output dmfp_pkg::t_out    o_out_word
);

    logic           r_valid, n_valid;
    dmfp_pkg::t_out r_word;

    // refill the output register when it is empty or being taken
    assign o_pop = i_q_stat.avail && (!r_valid || i_out_ready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_head;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

endmodule

[sim/dns_message_field_parser_tb.sv]
module dns_message_field_parser_tb;
    import dmfp_pkg::*;

    localparam int ITEM_TARGET = 1600;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_REPORTS = 20;

    class field_scoreboard;
        t_phase      phase;
        logic [1:0]  byte_pos;
        logic [31:0] acc;
        logic [15:0] counts [4];
        logic [1:0]  cur_sec;
        logic [15:0] cur_rec;
        logic [15:0] remaining;
        t_out        expected_fields [$];
        int          fails;

        function new();
            clear_parse();
            fails = 0;
        endfunction

        function void clear_parse();
            phase     = PH_IDLE;
            byte_pos  = '0;
            acc       = '0;
            for (int i = 0; i < 4; i++) counts[i] = '0;
            cur_sec   = '0;
            cur_rec   = '0;
            remaining = '0;
        endfunction

        function int pending();
            return expected_fields.size();
        endfunction

        // Move to the first record at or after (sec, rec); go idle if none is left.
        function bit seek_record(int sec, int rec);
            byte_pos = '0;
            acc      = '0;
            for (int s = sec; s < 4; s++) begin
                if (rec < counts[s]) begin
                    cur_sec = 2'(s);
                    cur_rec = 16'(rec);
                    phase   = (s == 0) ? PH_QNAME : PH_RRNAME;
                    return 1'b1;
                end
                rec = 0;
            end
            phase = PH_IDLE;
            return 1'b0;
        endfunction

        // Advance the parse by one accepted word; return 0 if the word was ignored.
        function bit note_byte(t_in w);
            logic [7:0]  b;
            logic [1:0]  sec;
            logic [15:0] rec;
            logic [31:0] val;
            t_kind       kind;
            t_out        field;
            bit          done;
            bit          emit;
            int          len;
            b    = w.data_byte;
            sec  = cur_sec;
            rec  = cur_rec;
            val  = '0;
            kind = K_ID;
            done = 1'b0;
            emit = 1'b1;
            if (w.start_req) begin
                clear_parse();
                phase = PH_HEADER;
                sec   = '0;
                rec   = '0;
            end
            if (phase == PH_IDLE) return 1'b0;

            if (phase == PH_QNAME) begin
                kind = K_QNAME;
                val  = {24'd0, b};
                if (b == 8'd0) begin
                    phase    = PH_QTYPE;
                    byte_pos = '0;
                    acc      = '0;
                end
            end else if (phase == PH_RDATA) begin
                kind      = K_RDATA;
                val       = {24'd0, b};
                remaining = remaining - 16'd1;
                if (remaining == 16'd0) done = !seek_record(int'(sec), int'(rec) + 1);
            end else begin
                len = (phase == PH_TTL) ? 4 : 2;
                acc = {acc[23:0], b};
                if (int'(byte_pos) + 1 < len) begin
                    byte_pos = byte_pos + 2'd1;
                    emit     = 1'b0;
                end else begin
                    val      = (len == 4) ? acc : {16'd0, acc[15:0]};
                    byte_pos = '0;
                    acc      = '0;
                    case (phase)
                        PH_HEADER: begin
                            // header fields are counted in the record register
                            kind = t_kind'(cur_rec[3:0]);
                            sec  = '0;
                            rec  = '0;
                            if (cur_rec >= 16'd2 && cur_rec <= 16'd5)
                                counts[cur_rec[1:0] - 2'd2] = val[15:0];
                            if (cur_rec < 16'd5) cur_rec = cur_rec + 16'd1;
                            else done = !seek_record(0, 0);
                        end
                        PH_QTYPE: begin
                            kind  = K_QTYPE;
                            phase = PH_QCLASS;
                        end
                        PH_QCLASS: begin
                            kind = K_QCLASS;
                            done = !seek_record(0, int'(rec) + 1);
                        end
                        PH_RRNAME: begin
                            kind  = K_RRNAME;
                            phase = PH_RRTYPE;
                        end
                        PH_RRTYPE: begin
                            kind  = K_RRTYPE;
                            phase = PH_RRCLASS;
                        end
                        PH_RRCLASS: begin
                            kind  = K_RRCLASS;
                            phase = PH_TTL;
                        end
                        PH_TTL: begin
                            kind  = K_TTL;
                            phase = PH_RDLEN;
                        end
                        default: begin
                            kind      = K_RDLENGTH;
                            remaining = val[15:0];
                            if (val == 32'd0) done = !seek_record(int'(sec), int'(rec) + 1);
                            else phase = PH_RDATA;
                        end
                    endcase
                end
            end

            if (emit) begin
                field.field_kind   = kind;
                field.section      = sec;
                field.record_index = rec;
                field.field_value  = val;
                field.message_done = done;
                expected_fields.push_back(field);
            end
            return 1'b1;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (fails < MAX_REPORTS)
                $display("mismatch %s: got %0h, expected %0h", what, got, want);
            fails++;
        endtask

        task check_field(t_out got);
            t_out want;
            if (expected_fields.size() == 0) begin
                report("unexpected field kind", 32'(got.field_kind), 32'hx);
                return;
            end
            want = expected_fields.pop_front();
            if (got.field_kind !== want.field_kind)
                report("field_kind", 32'(got.field_kind), 32'(want.field_kind));
            if (got.section !== want.section)
                report("section", 32'(got.section), 32'(want.section));
            if (got.record_index !== want.record_index)
                report("record_index", 32'(got.record_index), 32'(want.record_index));
            if (got.field_value !== want.field_value)
                report("field_value", got.field_value, want.field_value);
            if (got.message_done !== want.message_done)
                report("message_done", 32'(got.message_done), 32'(want.message_done));
        endtask
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic i_out_ready = 1'b0;
    t_in  i_in_word   = '0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_word;

    field_scoreboard sb = new();

    t_in         stream [$];
    int          active_items = 0;
    int unsigned cycles = 0;
    bit          hold_req = 1'b0;
    bit          hold_active = 1'b0;
    bit          burst = 1'b0;

    dns_message_field_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_field(o_out_word);
        end
    end

    // receiver: random ready runs, plus one long hold when asked
    initial begin
        int  run;
        int  r;
        bit  level;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_active = 1'b0;
            end else begin
                r = $urandom_range(0, 19);
                if (r < 3) begin
                    level = 1'b1;
                    run   = $urandom_range(50, 150);
                end else if (r == 3) begin
                    level = 1'b0;
                    run   = $urandom_range(15, 50);
                end else begin
                    level = ($urandom_range(0, 2) != 0);
                    run   = $urandom_range(1, 4);
                end
                i_out_ready <= level;
                repeat (run - 1) @(negedge i_clk);
            end
        end
    end

    function automatic t_in mk_word(logic [7:0] b, bit first);
        t_in w;
        w.data_byte = b;
        w.start_req = first;
        return w;
    endfunction

    function automatic void push_byte(logic [7:0] b, bit first);
        stream.push_back(mk_word(b, first));
    endfunction

    function automatic void push16(logic [15:0] v, bit first);
        push_byte(v[15:8], first);
        push_byte(v[7:0], 1'b0);
    endfunction

    function automatic void push32(logic [31:0] v);
        push16(v[31:16], 1'b0);
        push16(v[15:0], 1'b0);
    endfunction

    function automatic logic [15:0] pick16();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [31:0] pick32();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    // A broken message carries wild counts and lengths but only a few records,
    // and is cut short at a random byte.
    function automatic void build_message(bit broken);
        logic [15:0] cnt [4];
        int          made [4];
        int          len;
        int          keep;
        for (int i = 0; i < 4; i++) begin
            if (broken && $urandom_range(0, 1) == 1) cnt[i] = 16'($urandom_range(0, 65535));
            else if ($urandom_range(0, 15) == 0) cnt[i] = 16'd3;
            else cnt[i] = 16'($urandom_range(0, 2));
            made[i] = (cnt[i] > 16'd3) ? 3 : int'(cnt[i]);
        end
        push16(pick16(), 1'b1);
        push16(pick16(), 1'b0);
        for (int i = 0; i < 4; i++) push16(cnt[i], 1'b0);
        for (int q = 0; q < made[0]; q++) begin
            repeat ($urandom_range(0, 10)) push_byte(8'($urandom_range(1, 255)), 1'b0);
            push_byte(8'd0, 1'b0);
            push16(pick16(), 1'b0);
            push16(pick16(), 1'b0);
        end
        for (int s = 1; s < 4; s++) begin
            for (int k = 0; k < made[s]; k++) begin
                push16(16'hC000 | 16'($urandom_range(0, 16383)), 1'b0);
                push16(pick16(), 1'b0);
                push16(pick16(), 1'b0);
                push32(pick32());
                if (broken && $urandom_range(0, 1) == 1) len = $urandom_range(0, 65535);
                else if ($urandom_range(0, 4) == 0) len = 0;
                else len = $urandom_range(1, 6);
                push16(16'(len), 1'b0);
                repeat ((len > 6) ? 6 : len) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end
        if (broken) begin
            keep = $urandom_range(1, stream.size());
            while (stream.size() > keep) void'(stream.pop_back());
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst || hold_active) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(t_in w, int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        if (sb.note_byte(w)) active_items++;
        @(negedge i_clk);
    endtask

    task automatic send_stream();
        while (stream.size() > 0) send_word(stream.pop_front(), pick_gap());
    endtask

    task automatic idle_input();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int  r;
        int  messages;
        bit  hold_started;
        messages     = 0;
        hold_started = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // byte before any start is ignored
        push_byte(8'hFF, 1'b0);
        // empty message: all counts zero, arcount is final
        push16(16'hFFFF, 1'b1);
        push16(16'h0000, 1'b0);
        repeat (4) push16(16'h0000, 1'b0);
        // bytes after the final field are dropped
        push_byte(8'h5A, 1'b0);
        // header cut short by a new start
        push16(16'h1234, 1'b1);
        push16(16'hFFFF, 1'b0);
        push_byte(8'h00, 1'b0);
        send_stream();

        while (active_items < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            if (r < 8) begin
                build_message(1'b0);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (r == 8) begin
                build_message(1'b1);
            end else begin
                repeat ($urandom_range(1, 8))
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
            end
            burst = ($urandom_range(0, 3) == 0);
            if (!hold_started && active_items >= 700) begin
                hold_started = 1'b1;
                hold_req     = 1'b1;
            end
            send_stream();
            messages++;
            // pause the sender until the output side has caught up
            if (messages % 15 == 14) begin
                idle_input();
                wait_drained();
            end
        end

        idle_input();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
